// ===== design/yuyv2rgb_pkg.sv =====
// Shared types, constants and helper functions for the YUYV to RGB565/BGR24 unit.
// No dependencies; every other file imports this package.

package yuyv2rgb_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W      = 8;
	localparam int RGB565_W   = 16;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int COUNT_W    = 12;
	localparam int SCREEN_W   = 24;
	localparam int BITMAP_W   = 26;
	localparam int STEP_W     = CFG_W + 1;
	localparam int TERM_W     = 20;
	localparam int SUM_W      = 21;

	localparam int K_Y        = 298;
	localparam int K_RV       = 409;
	localparam int K_GU       = 100;
	localparam int K_GV       = 208;
	localparam int K_BU       = 516;
	localparam int ROUND      = 128;
	localparam int CHROMA_OFS = 128;
	localparam int PIX_MAX    = 255;

	localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH  = CFG_W'(100);
	localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT = CFG_W'(75);
	localparam logic [CFG_W-1:0] RESET_SCREEN_WIDTH = CFG_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_SCREEN_WIDTH = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		SEQ_RUN  = 4'b0001,
		SEQ_DIMS = 4'b0010,
		SEQ_PROD = 4'b0100,
		SEQ_LOAD = 4'b1000
	} seq_state_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} stage_en_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] rv;
		logic signed [TERM_W-1:0] gu;
		logic signed [TERM_W-1:0] gv;
		logic signed [TERM_W-1:0] bu;
	} chroma_terms_t;

	typedef struct packed {
		logic [RGB565_W-1:0] packed565;
		logic [PIX_W-1:0]    blue;
		logic [PIX_W-1:0]    green;
		logic [PIX_W-1:0]    red;
	} pixel_t;

	typedef struct packed {
		logic [SCREEN_W-1:0] screen_index;
		logic [BITMAP_W-1:0] bitmap_offset;
		logic                frame_end;
	} addr_item_t;

	// Clamp to 2..MAX_WIDTH, round up to even, back off by two if that overshoots.
	function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] raw);
		logic [CFG_W:0] w;
		w = {1'b0, raw};
		if (w < (CFG_W+1)'(2)) w = (CFG_W+1)'(2);
		if (w > (CFG_W+1)'(MAX_WIDTH)) w = (CFG_W+1)'(MAX_WIDTH);
		w = w + {{CFG_W{1'b0}}, w[0]};
		if (w > (CFG_W+1)'(MAX_WIDTH)) w = w - (CFG_W+1)'(2);
		return w[CFG_W-1:0];
	endfunction

	function automatic logic [CFG_W-1:0] eff_height(input logic [CFG_W-1:0] raw);
		logic [CFG_W:0] h;
		h = {1'b0, raw};
		if (h < (CFG_W+1)'(1)) h = (CFG_W+1)'(1);
		if (h > (CFG_W+1)'(MAX_HEIGHT)) h = (CFG_W+1)'(MAX_HEIGHT);
		return h[CFG_W-1:0];
	endfunction

	function automatic logic [CFG_W-1:0] eff_screen(input logic [CFG_W-1:0] raw,
			input logic [CFG_W-1:0] w);
		logic [CFG_W:0] s;
		s = {1'b0, raw};
		if (s < {1'b0, w}) s = {1'b0, w};
		if (s > (CFG_W+1)'(MAX_WIDTH)) s = (CFG_W+1)'(MAX_WIDTH);
		s = s + {{CFG_W{1'b0}}, s[0]};
		return s[CFG_W-1:0];
	endfunction

	// floor(x / 256) limited to 0..255
	function automatic logic [PIX_W-1:0] scale_clamp(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-9:0] q;
		q = x[SUM_W-1:8];
		if (q < 0) return '0;
		if (q > PIX_MAX) return PIX_W'(PIX_MAX);
		return q[PIX_W-1:0];
	endfunction

	function automatic logic [RGB565_W-1:0] pack565(input logic [PIX_W-1:0] r,
			input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
		return {r[PIX_W-1:3], g[PIX_W-1:2], b[PIX_W-1:3]};
	endfunction

	localparam logic [CFG_W-1:0] RESET_EFF_WIDTH  = eff_width(RESET_IMAGE_WIDTH);
	localparam logic [CFG_W-1:0] RESET_EFF_HEIGHT = eff_height(RESET_IMAGE_HEIGHT);
	localparam logic [CFG_W-1:0] RESET_EFF_SCREEN =
		eff_screen(RESET_SCREEN_WIDTH, RESET_EFF_WIDTH);
	localparam logic [STEP_W-1:0] RESET_ROW_STEP = STEP_W'(3 * int'(RESET_EFF_WIDTH));
	localparam logic [BITMAP_W-1:0] RESET_FRAME_BASE =
		BITMAP_W'((int'(RESET_EFF_HEIGHT) - 1) * int'(RESET_ROW_STEP));

endpackage

// ===== design/yuyv2rgb_if.sv =====
// Channel interfaces: YUYV input items, RGB result items, configuration writes.
// Depends on yuyv2rgb_pkg for field widths.

interface yuyv_in_if import yuyv2rgb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] luma_first;
	logic [PIX_W-1:0] chroma_blue;
	logic [PIX_W-1:0] luma_second;
	logic [PIX_W-1:0] chroma_red;

	modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
		input ready);
	modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
		output ready);
endinterface

interface rgb_out_if import yuyv2rgb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [RGB565_W-1:0] packed_first;
	logic [RGB565_W-1:0] packed_second;
	logic [PIX_W-1:0]    blue_first;
	logic [PIX_W-1:0]    green_first;
	logic [PIX_W-1:0]    red_first;
	logic [PIX_W-1:0]    blue_second;
	logic [PIX_W-1:0]    green_second;
	logic [PIX_W-1:0]    red_second;
	logic [SCREEN_W-1:0] screen_index;
	logic [BITMAP_W-1:0] bitmap_offset;
	logic                frame_end;

	modport source (output valid, packed_first, packed_second, blue_first, green_first,
		red_first, blue_second, green_second, red_second, screen_index, bitmap_offset,
		frame_end, input ready);
	modport sink (input valid, packed_first, packed_second, blue_first, green_first,
		red_first, blue_second, green_second, red_second, screen_index, bitmap_offset,
		frame_end, output ready);
endinterface

interface cfg_wr_if import yuyv2rgb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/yuyv_to_rgb565_bgr24_unit.sv =====
// Top level: YUYV macropixel to two RGB565/BGR24 pixels plus framebuffer and BMP addresses.
// Depends on yuyv2rgb_pkg, the channel interfaces, chroma, lane, addr and merge modules.
//
//  channel     dir  handshake     payload
//  pixel_in    in   valid/ready   luma_first, chroma_blue, luma_second, chroma_red
//  pixel_out   out  valid/ready   packed_*, blue/green/red_*, screen_index, bitmap_offset,
//                                 frame_end
//  cfg         in   valid/ready   index (0 width, 1 height, 2 screen width), data
//
// One item per cycle while pixel_out is ready and no restart runs: stage 1 holds the
// constant products, stage 2 the sums, clamps and packing (the output register).
// While a result waits, stage 1 takes one more item and then input stalls; with both
// stages full, pixel_in.ready follows pixel_out.ready in the same cycle.
// Reset loads the default geometry directly. A configuration write runs a restart
// (dimensions, row-offset multiply, counter load) during which no item is taken.

module yuyv_to_rgb565_bgr24_unit import yuyv2rgb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	yuyv_in_if.sink   pixel_in,
	rgb_out_if.source pixel_out,
	cfg_wr_if.sink    cfg
);

	logic          busy;
	logic          in_ready;
	logic          in_take;
	logic          s1_valid_q;
	logic          s2_valid_q;
	logic          s1_move;
	logic          s2_move;
	stage_en_t     en;
	addr_item_t    addr_item;
	addr_item_t    addr_s1;
	chroma_terms_t terms_s1;
	pixel_t        pix_first_s2;
	pixel_t        pix_second_s2;

	assign s2_move  = !s2_valid_q || pixel_out.ready;
	assign s1_move  = !s1_valid_q || s2_move;
	assign in_ready = s1_move && !busy;
	assign in_take  = pixel_in.valid && in_ready;

	assign pixel_in.ready  = in_ready;
	assign pixel_out.valid = s2_valid_q;

	assign en.s1 = in_take;
	assign en.s2 = s1_valid_q && s2_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_move) begin
				s1_valid_q <= in_take;
			end
			if (s2_move) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			addr_s1 <= addr_item;
		end
	end

	yuyv2rgb_addr u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.take   (in_take),
		.busy   (busy),
		.item   (addr_item)
	);

	yuyv2rgb_chroma u_chroma (
		.clk      (clk),
		.en       (en),
		.u        (pixel_in.chroma_blue),
		.v        (pixel_in.chroma_red),
		.terms_s1 (terms_s1)
	);

	yuyv2rgb_lane u_lane_first (
		.clk      (clk),
		.en       (en),
		.y        (pixel_in.luma_first),
		.terms_s1 (terms_s1),
		.pix_s2   (pix_first_s2)
	);

	yuyv2rgb_lane u_lane_second (
		.clk      (clk),
		.en       (en),
		.y        (pixel_in.luma_second),
		.terms_s1 (terms_s1),
		.pix_s2   (pix_second_s2)
	);

	yuyv2rgb_merge u_merge (
		.clk           (clk),
		.en            (en),
		.addr_s1       (addr_s1),
		.pix_first_s2  (pix_first_s2),
		.pix_second_s2 (pix_second_s2),
		.pixel_out     (pixel_out)
	);

	// a valid register write restarts the frame: hold off input the next cycle
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready && (cfg.index == REG_IMAGE_WIDTH
			|| cfg.index == REG_IMAGE_HEIGHT || cfg.index == REG_SCREEN_WIDTH)
		|=> !in_take)
		else $error("item accepted during frame restart");

	// a stalled stage 1 item must not be lost
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s2_move |=> s1_valid_q)
		else $error("stage 1 item dropped while output stalled");

	// an item entering an empty pipeline reaches the output through stage 1 and stage 2
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !s1_valid_q && !s2_valid_q |-> ##2 s2_valid_q)
		else $error("result missing two cycles after acceptance");

endmodule

// ===== design/yuyv2rgb_chroma.sv =====
// Shared chroma products for both pixel lanes, registered in stage 1.
// Depends on yuyv2rgb_pkg.

module yuyv2rgb_chroma import yuyv2rgb_pkg::*; (
	input  logic             clk,
	input  stage_en_t        en,
	input  logic [PIX_W-1:0] u,
	input  logic [PIX_W-1:0] v,
	output chroma_terms_t    terms_s1
);

	logic signed [PIX_W:0] u_c;
	logic signed [PIX_W:0] v_c;

	// remove the 128 offset
	assign u_c = $signed({1'b0, u}) - (PIX_W+1)'(CHROMA_OFS);
	assign v_c = $signed({1'b0, v}) - (PIX_W+1)'(CHROMA_OFS);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			terms_s1.rv <= TERM_W'(K_RV * v_c);
			terms_s1.gu <= TERM_W'(K_GU * u_c);
			terms_s1.gv <= TERM_W'(K_GV * v_c);
			terms_s1.bu <= TERM_W'(K_BU * u_c);
		end
	end

endmodule

// ===== design/yuyv2rgb_lane.sv =====
// One pixel lane: luma product in stage 1, sums, clamp and RGB565 pack in stage 2.
// Depends on yuyv2rgb_pkg and the chroma terms from yuyv2rgb_chroma.

module yuyv2rgb_lane import yuyv2rgb_pkg::*; (
	input  logic             clk,
	input  stage_en_t        en,
	input  logic [PIX_W-1:0] y,
	input  chroma_terms_t    terms_s1,
	output pixel_t           pix_s2
);

	logic signed [TERM_W-1:0] y_term_s1;
	logic signed [SUM_W-1:0]  r_sum;
	logic signed [SUM_W-1:0]  g_sum;
	logic signed [SUM_W-1:0]  b_sum;
	logic [PIX_W-1:0]         r_val;
	logic [PIX_W-1:0]         g_val;
	logic [PIX_W-1:0]         b_val;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			y_term_s1 <= TERM_W'(K_Y * $signed({1'b0, y}));
		end
	end

	always_comb begin
		r_sum = SUM_W'(y_term_s1) + SUM_W'(terms_s1.rv) + SUM_W'(ROUND);
		g_sum = SUM_W'(y_term_s1) - SUM_W'(terms_s1.gu) - SUM_W'(terms_s1.gv)
			+ SUM_W'(ROUND);
		b_sum = SUM_W'(y_term_s1) + SUM_W'(terms_s1.bu) + SUM_W'(ROUND);
		r_val = scale_clamp(r_sum);
		g_val = scale_clamp(g_sum);
		b_val = scale_clamp(b_sum);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pix_s2.red       <= r_val;
			pix_s2.green     <= g_val;
			pix_s2.blue      <= b_val;
			pix_s2.packed565 <= pack565(r_val, g_val, b_val);
		end
	end

endmodule

// ===== design/yuyv2rgb_addr.sv =====
// Configuration registers, frame restart sequencer and the row/column address counters.
// Depends on yuyv2rgb_pkg and the cfg_wr_if interface.

module yuyv2rgb_addr import yuyv2rgb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	cfg_wr_if.sink        cfg,
	input  logic          take,
	output logic          busy,
	output addr_item_t    item
);

	logic [CFG_W-1:0]    img_w_q;
	logic [CFG_W-1:0]    img_h_q;
	logic [CFG_W-1:0]    scr_w_q;
	logic [CFG_W-1:0]    w_eff;
	logic [CFG_W-1:0]    h_eff;
	logic [COUNT_W-1:0]  pairs_q;
	logic [COUNT_W-1:0]  last_row_q;
	logic [CFG_W-1:0]    stride_q;
	logic [STEP_W-1:0]   row_step_q;
	logic [BITMAP_W-1:0] frame_base_q;
	logic [COUNT_W-1:0]  col_q;
	logic [COUNT_W-1:0]  row_q;
	logic [SCREEN_W-1:0] screen_base_q;
	logic [SCREEN_W-1:0] screen_ptr_q;
	logic [BITMAP_W-1:0] bitmap_base_q;
	logic [BITMAP_W-1:0] bitmap_ptr_q;
	logic [SCREEN_W-1:0] screen_next;
	logic [BITMAP_W-1:0] bitmap_next;
	logic                cfg_hit;
	logic                row_done;
	logic                frame_done;
	seq_state_t          seq_q;

	assign cfg.ready = 1'b1;

	always_comb begin
		unique case (cfg_reg_t'(cfg.index))
			REG_IMAGE_WIDTH,
			REG_IMAGE_HEIGHT,
			REG_SCREEN_WIDTH: cfg_hit = cfg.valid;
			default:          cfg_hit = 1'b0;
		endcase
	end

	assign w_eff = eff_width(img_w_q);
	assign h_eff = eff_height(img_h_q);

	assign row_done    = ({1'b0, col_q} + (COUNT_W+1)'(1)) >= {1'b0, pairs_q};
	assign frame_done  = row_done && (row_q >= last_row_q);
	assign screen_next = screen_base_q + SCREEN_W'(stride_q);
	assign bitmap_next = bitmap_base_q - BITMAP_W'(row_step_q);

	assign busy               = (seq_q != SEQ_RUN);
	assign item.screen_index  = screen_ptr_q;
	assign item.bitmap_offset = bitmap_ptr_q;
	assign item.frame_end     = frame_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q       <= RESET_IMAGE_WIDTH;
			img_h_q       <= RESET_IMAGE_HEIGHT;
			scr_w_q       <= RESET_SCREEN_WIDTH;
			pairs_q       <= COUNT_W'(RESET_EFF_WIDTH >> 1);
			last_row_q    <= COUNT_W'(RESET_EFF_HEIGHT - CFG_W'(1));
			stride_q      <= RESET_EFF_SCREEN;
			row_step_q    <= RESET_ROW_STEP;
			frame_base_q  <= RESET_FRAME_BASE;
			col_q         <= '0;
			row_q         <= '0;
			screen_base_q <= '0;
			screen_ptr_q  <= '0;
			bitmap_base_q <= RESET_FRAME_BASE;
			bitmap_ptr_q  <= RESET_FRAME_BASE;
			seq_q         <= SEQ_RUN;
		end else begin
			if (cfg_hit) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_IMAGE_WIDTH:  img_w_q <= cfg.data;
					REG_IMAGE_HEIGHT: img_h_q <= cfg.data;
					REG_SCREEN_WIDTH: scr_w_q <= cfg.data;
					default:          img_w_q <= img_w_q;
				endcase
				seq_q <= SEQ_DIMS;
			end else begin
				unique case (seq_q)
					SEQ_DIMS: begin
						pairs_q    <= COUNT_W'(w_eff >> 1);
						last_row_q <= COUNT_W'(h_eff - CFG_W'(1));
						stride_q   <= eff_screen(scr_w_q, w_eff);
						row_step_q <= STEP_W'(w_eff) + {w_eff, 1'b0};
						seq_q      <= SEQ_PROD;
					end
					SEQ_PROD: begin
						frame_base_q <= BITMAP_W'(last_row_q * row_step_q);
						seq_q        <= SEQ_LOAD;
					end
					SEQ_LOAD: begin
						col_q         <= '0;
						row_q         <= '0;
						screen_base_q <= '0;
						screen_ptr_q  <= '0;
						bitmap_base_q <= frame_base_q;
						bitmap_ptr_q  <= frame_base_q;
						seq_q         <= SEQ_RUN;
					end
					default: begin
						seq_q <= SEQ_RUN;
					end
				endcase
			end

			if (take) begin
				priority if (frame_done) begin
					col_q         <= '0;
					row_q         <= '0;
					screen_base_q <= '0;
					screen_ptr_q  <= '0;
					bitmap_base_q <= frame_base_q;
					bitmap_ptr_q  <= frame_base_q;
				end else if (row_done) begin
					col_q         <= '0;
					row_q         <= row_q + COUNT_W'(1);
					screen_base_q <= screen_next;
					screen_ptr_q  <= screen_next;
					bitmap_base_q <= bitmap_next;
					bitmap_ptr_q  <= bitmap_next;
				end else begin
					col_q        <= col_q + COUNT_W'(1);
					screen_ptr_q <= screen_ptr_q + SCREEN_W'(2);
					bitmap_ptr_q <= bitmap_ptr_q + BITMAP_W'(6);
				end
			end
		end
	end

endmodule

// ===== design/yuyv2rgb_to_rgb565_bgr24_unit.sv =====
// Merge stage: joins both pixel lanes and the delayed address item into one result item.
// Depends on yuyv2rgb_pkg and the rgb_out_if interface.

module yuyv2rgb_merge import yuyv2rgb_pkg::*; (
	input  logic       clk,
	input  stage_en_t  en,
	input  addr_item_t addr_s1,
	input  pixel_t     pix_first_s2,
	input  pixel_t     pix_second_s2,
	rgb_out_if.source  pixel_out
);

	addr_item_t addr_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			addr_s2 <= addr_s1;
		end
	end

	// join both lanes and the address fields into one result item
	assign pixel_out.packed_first  = pix_first_s2.packed565;
	assign pixel_out.packed_second = pix_second_s2.packed565;
	assign pixel_out.blue_first    = pix_first_s2.blue;
	assign pixel_out.green_first   = pix_first_s2.green;
	assign pixel_out.red_first     = pix_first_s2.red;
	assign pixel_out.blue_second   = pix_second_s2.blue;
	assign pixel_out.green_second  = pix_second_s2.green;
	assign pixel_out.red_second    = pix_second_s2.red;
	assign pixel_out.screen_index  = addr_s2.screen_index;
	assign pixel_out.bitmap_offset = addr_s2.bitmap_offset;
	assign pixel_out.frame_end     = addr_s2.frame_end;

endmodule
